FILE: rtl/lph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, constants and hash helper for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int Slots     = 256;
  localparam int SlotBits  = $clog2(Slots);
  localparam int CountBits = $clog2(Slots + 1);

  localparam logic [31:0] FnvBasis = 32'h811C9DC5;
  localparam logic [31:0] FnvPrime = 32'h01000193;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SL_EMPTY  = 2'd0,
    SL_FILLED = 2'd1,
    SL_TOMB   = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_OUT
  } fsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic hash_step; // one FNV byte
    logic start;     // set probe position from hash
    logic read;      // issue slot read
    logic advance;   // step probe position
    logic do_write;  // fill slot at probe position
    logic do_tomb;   // tombstone slot at probe position
    logic set_res;   // capture result
    status_t res_status;
    logic res_slot;  // result carries slot index
    logic res_value; // result carries stored value
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t         op;
    logic        hash_done;
    logic        limit_hit;
    slot_state_t slot_state;
    logic        key_match;
    logic        hash_match;
    logic        last_probe;
  } stat_t;

  // One FNV-1a byte round
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/linear_probe_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// 64-bit key to value map, open addressing with linear probing.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// input     in_valid / in_stall        operation, key, value
// output    out_valid / out_stall      status, found_value, slot_index, live_count
// config    cfg_valid / cfg_ready      cfg_data (occupancy limit)
//
// One item at a time: an accept, the hash (eight bytes and a start), a read
// and a check per probe, and a publish step for the result; the hash unit and
// the single slot read port set the pace. Reset clears a used bit per slot and
// the counters at once. A stalled result holds in the output register; the next
// item may be accepted once the held result is being taken.
module linear_probe_hash_table_core import lph_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           operation,
  input  wire logic [63:0]          key,
  input  wire logic [63:0]          value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [63:0]               found_value,
  output logic [7:0]                slot_index,
  output logic [CountBits-1:0]      live_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CountBits-1:0] cfg_data
);

  cmd_t                 cmd;
  stat_t                stat;
  logic [CountBits-1:0] limit;

  // Occupancy limit register
  always_ff @(posedge clk) begin
    if (rst) limit <= CountBits'(192);
    else if (cfg_valid && cfg_ready) limit <= cfg_data;
  end
  assign cfg_ready = 1'b1;

  lph_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  lph_datapath u_dp (
    .clk, .rst, .cmd, .stat, .operation, .key, .value, .limit,
    .status, .found_value, .slot_index, .live_count
  );

endmodule
`default_nettype wire

FILE: rtl/lph_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lph_datapath
// Hash unit, probe counter, slot memories, counters and result register.
// ----------------------------------------------------------------------------
module lph_datapath import lph_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  input  wire logic [1:0]           operation,
  input  wire logic [63:0]          key,
  input  wire logic [63:0]          value,
  input  wire logic [CountBits-1:0] limit,
  output logic [1:0]                status,
  output logic [63:0]               found_value,
  output logic [7:0]                slot_index,
  output logic [CountBits-1:0]      live_count
);

  logic [1:0]           op_q;
  logic [63:0]          key_q;
  logic [63:0]          value_q;
  logic [31:0]          hash;
  logic [2:0]           byte_cnt;
  logic                 hash_done;
  logic [SlotBits-1:0]  pos;
  logic [CountBits-1:0] probes;
  logic [CountBits-1:0] filled;
  logic [CountBits-1:0] tombs;

  // Slot memories; a used bit per slot makes never-written slots read as empty
  logic [Slots-1:0] slot_used;
  logic [1:0]  mem_state [Slots];
  logic [31:0] mem_hash  [Slots];
  logic [63:0] mem_key   [Slots];
  logic [63:0] mem_value [Slots];
  logic [1:0]  rd_state;
  logic [31:0] rd_hash;
  logic [63:0] rd_key;
  logic [63:0] rd_value;

  // Capture item and run the hash a byte a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_done <= 1'b0;
      byte_cnt  <= '0;
    end else if (cmd.load) begin
      op_q      <= operation;
      key_q     <= key;
      value_q   <= value;
      hash      <= FnvBasis;
      byte_cnt  <= '0;
      hash_done <= 1'b0;
    end else if (cmd.hash_step) begin
      hash     <= fnv_round(hash, key_q[8*byte_cnt +: 8]);
      byte_cnt <= byte_cnt + 3'd1;
      if (byte_cnt == 3'd7) hash_done <= 1'b1;
    end
  end

  // Probe position and count
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos    <= hash[SlotBits-1:0];
      probes <= '0;
    end else if (cmd.advance) begin
      pos    <= pos + 1'b1;
      probes <= probes + 1'b1;
    end
  end

  // Used bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (cmd.do_write) begin
      slot_used[pos] <= 1'b1;
    end
  end

  // Slot status memory
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      mem_state[pos] <= SL_FILLED;
    end else if (cmd.do_tomb) begin
      mem_state[pos] <= SL_TOMB;
    end
  end

  // Payload memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      mem_hash[pos]  <= hash;
      mem_key[pos]   <= key_q;
      mem_value[pos] <= value_q;
    end
    if (cmd.read) begin
      rd_state <= slot_used[pos] ? mem_state[pos] : SL_EMPTY;
      rd_hash  <= mem_hash[pos];
      rd_key   <= mem_key[pos];
      rd_value <= mem_value[pos];
    end
  end

  // Occupancy counters
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      tombs  <= '0;
    end else if (cmd.do_write) begin
      filled <= filled + 1'b1;
      if (rd_state == SL_TOMB && tombs != '0) tombs <= tombs - 1'b1;
    end else if (cmd.do_tomb) begin
      if (filled != '0) filled <= filled - 1'b1;
      tombs <= tombs + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      status      <= cmd.res_status;
      found_value <= cmd.res_value ? rd_value : 64'd0;
      slot_index  <= cmd.res_slot ? 8'(pos) : 8'd0;
    end
  end

  assign live_count = filled;

  always_comb begin
    stat.op         = op_t'(op_q);
    stat.hash_done  = hash_done;
    stat.limit_hit  = (filled >= limit);
    stat.slot_state = slot_state_t'(rd_state);
    stat.key_match  = (rd_key == key_q);
    stat.hash_match = (rd_hash == hash);
    stat.last_probe = (probes == CountBits'(Slots - 1));
  end

endmodule
`default_nettype wire

FILE: rtl/lph_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer for hash, probe and write-back of one item.
// ----------------------------------------------------------------------------
module lph_ctrl import lph_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  fsm_state_t state, state_next;
  logic       res_pend;

  // Result holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Hold off the next item while a result is waiting
  assign res_pend = out_valid && out_stall;
  assign in_stall = (state != S_IDLE) || res_pend;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && !res_pend) state_next = S_HASH;
      S_HASH: begin
        if (stat.hash_done) begin
          if (stat.op == OP_UNUSED ||
              (stat.op == OP_INSERT && stat.limit_hit)) state_next = S_OUT;
          else state_next = S_READ;
        end
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        state_next = S_OUT;
        if (stat.op == OP_INSERT) begin
          if (stat.slot_state == SL_FILLED && !stat.key_match && !stat.last_probe)
            state_next = S_READ;
        end else if (stat.slot_state != SL_EMPTY &&
                     !(stat.slot_state == SL_FILLED && stat.hash_match &&
                       stat.key_match) && !stat.last_probe) begin
          state_next = S_READ;
        end
      end
      S_OUT:   if (!res_pend) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    logic hit;
    cmd = '0;
    cmd.res_status = ST_NOTFOUND;
    hit = stat.slot_state == SL_FILLED && stat.hash_match && stat.key_match;
    case (state)
      S_IDLE: cmd.load = in_valid && !res_pend;
      S_HASH: begin
        cmd.hash_step = !stat.hash_done;
        cmd.start     = stat.hash_done;
        if (stat.hash_done) begin
          if (stat.op == OP_INSERT && stat.limit_hit) begin
            cmd.set_res = 1'b1; cmd.res_status = ST_FULL;
          end else if (stat.op == OP_UNUSED) begin
            cmd.set_res = 1'b1;
          end
        end
      end
      S_READ: cmd.read = 1'b1;
      S_CHECK: begin
        if (stat.op == OP_INSERT) begin
          if (stat.slot_state != SL_FILLED) begin
            cmd.do_write = 1'b1; cmd.set_res = 1'b1;
            cmd.res_status = ST_DONE; cmd.res_slot = 1'b1;
          end else if (stat.key_match) begin
            cmd.set_res = 1'b1; cmd.res_status = ST_DUP;
          end else if (stat.last_probe) begin
            cmd.set_res = 1'b1; cmd.res_status = ST_FULL;
          end else cmd.advance = 1'b1;
        end else if (hit) begin
          cmd.set_res = 1'b1; cmd.res_status = ST_DONE; cmd.res_slot = 1'b1;
          cmd.res_value = (stat.op == OP_LOOKUP);
          cmd.do_tomb   = (stat.op == OP_REMOVE);
        end else if (stat.slot_state == SL_EMPTY || stat.last_probe) begin
          cmd.set_res = 1'b1;
        end else cmd.advance = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/lph_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks on the hash table core.
// ----------------------------------------------------------------------------
module lph_checker import lph_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [1:0]           status,
  input wire logic [63:0]          found_value,
  input wire logic [7:0]           slot_index,
  input wire logic [CountBits-1:0] live_count
);

  // Held status and live count do not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(live_count))
    else $error("held result changed");

  // An accepted item never produces a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid || $past(out_valid))
    else $error("result too early");

  // Value only on success
  a_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> found_value == 64'd0)
    else $error("value on failure");

  // Slot index zero on any status but done
  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> slot_index == 8'd0)
    else $error("slot on failure");

  // Live count never exceeds the slot count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    live_count <= CountBits'(Slots))
    else $error("live count overflow");

endmodule

bind linear_probe_hash_table_core lph_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .found_value, .slot_index, .live_count
);
`default_nettype wire
